>>> rtl/inventory_skewed_quote_generator_macros.svh
// assertion macros for the quote generator checker
`ifndef INVENTORY_SKEWED_QUOTE_GENERATOR_MACROS_SVH
`define INVENTORY_SKEWED_QUOTE_GENERATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISQG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISQG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/isqg_pkg.sv
package isqg_pkg;

  // default instrument count
  localparam int unsigned NUM_INSTR_DEF = 32;

  // field widths
  localparam int unsigned INSTR_W    = 5;
  localparam int unsigned PRICE_W    = 40;
  localparam int unsigned MID_W      = 41;
  localparam int unsigned QUOTE_W    = 41;
  localparam int unsigned NET_W      = 16;
  localparam int unsigned SPREAD_W   = 8;
  localparam int unsigned MAXPOS_W   = 15;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  // internal widths
  localparam int unsigned OFFS_W    = SPREAD_W + TICK_W;
  localparam int unsigned WORK_W    = MID_W + 2;
  localparam int unsigned DIV_CNT_W = $clog2(MID_W + 1);

  // register reset values
  localparam logic [SPREAD_W-1:0]   SPREAD_RST = SPREAD_W'(2);
  localparam logic [MAXPOS_W-1:0]   MAXPOS_RST = MAXPOS_W'(5);
  localparam logic [TICK_W-1:0]     TICK_RST   = TICK_W'(2000);
  localparam logic [CFG_DATA_W-1:0] MINPX_RST  = CFG_DATA_W'(1000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPREAD_TICKS = 2'd0,
    CFG_MAX_NET_POS  = 2'd1,
    CFG_TICK_INCR    = 2'd2,
    CFG_MIN_VALID    = 2'd3
  } cfg_idx_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_READY = 3'd0,
    ST_DIRTY     = 3'd1,
    ST_AT_LIMIT  = 3'd2,
    ST_MID_SAME  = 3'd3,
    ST_CROSSED   = 3'd4,
    ST_REQUOTED  = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_QUOTE,
    S_FIN,
    S_DONE
  } state_e;

  // remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/isqg_rem_unit.sv
module isqg_rem_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [isqg_pkg::MID_W-1:0]     dividend_i,
  input  logic [isqg_pkg::TICK_W-1:0]    divisor_i,
  output logic [isqg_pkg::TICK_W-1:0]    rem_o,
  output isqg_pkg::div_stat_t            stat_o
);
  import isqg_pkg::*;

  logic [MID_W-1:0]     dvd_q, dvd_d;
  logic [TICK_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [TICK_W:0]      trial;
  logic                 fits;

  // one restoring step per cycle, dividend bits msb first
  always_comb begin
    trial  = {rem_q, dvd_q[MID_W-1]};
    fits   = (trial >= {1'b0, divisor_i});
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(MID_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[MID_W-2:0], 1'b0};
      rem_d = fits ? TICK_W'(trial - {1'b0, divisor_i}) : trial[TICK_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> rtl/inventory_skewed_quote_generator.sv
// channel   direction  handshake               payload
// tick      in         in_valid_i/in_stall_o   instrument .. net_position
// quote     out        out_valid_o/out_stall_i status, bid/ask send, quote, closes
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// a requoting tick passes through evaluation, 41 steps of a radix-2 remainder unit
// (mid modulo the tick, one dividend bit per cycle), remainder capture, quote, finish and
// the output register; a skipped tick goes from evaluation to the output register
// one tick at a time: in_stall_o is high from acceptance until the result is
// registered, and a result still stalled at the output holds the next one back
// reset clears the stored mids through per-instrument valid bits, no sweep
module inventory_skewed_quote_generator #(
  parameter int unsigned NUM_INSTRUMENTS = isqg_pkg::NUM_INSTR_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [isqg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [isqg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // tick channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [isqg_pkg::INSTR_W-1:0]      instrument_i,
  input  logic                              engine_ready_i,
  input  logic [isqg_pkg::PRICE_W-1:0]      bid_in_i,
  input  logic [isqg_pkg::PRICE_W-1:0]      ask_in_i,
  input  logic [isqg_pkg::PRICE_W-1:0]      last_trade_i,
  input  logic [isqg_pkg::PRICE_W-1:0]      upper_bound_i,
  input  logic [isqg_pkg::PRICE_W-1:0]      lower_bound_i,
  input  logic signed [isqg_pkg::NET_W-1:0] net_position_i,
  // quote channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [isqg_pkg::STATUS_W-1:0]     status_o,
  output logic                              bid_send_o,
  output logic signed [isqg_pkg::QUOTE_W-1:0] bid_quote_o,
  output logic                              bid_closes_o,
  output logic                              ask_send_o,
  output logic [isqg_pkg::QUOTE_W-1:0]      ask_quote_o,
  output logic                              ask_closes_o
);
  import isqg_pkg::*;

  localparam int unsigned IDX_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int unsigned CMP_W = ((IDX_W + 1) > INSTR_W) ? (IDX_W + 1) : INSTR_W;
  localparam logic [CMP_W-1:0] NUM_C = CMP_W'(NUM_INSTRUMENTS);

  // configuration registers
  logic [SPREAD_W-1:0]   spread_q;
  logic [MAXPOS_W-1:0]   maxpos_q;
  logic [TICK_W-1:0]     tick_q;
  logic [CFG_DATA_W-1:0] minpx_q;

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   div_start;
  logic   push;
  logic   eval_go;
  status_e eval_status;

  // latched tick
  logic                    ready_q;
  logic                    inrange_q;
  logic [IDX_W-1:0]        idx_q;
  logic [PRICE_W-1:0]      bid_q, ask_q, last_q, upper_q, lower_q;
  logic signed [NET_W-1:0] net_q;

  // stored mids
  logic [MID_W-1:0]           mid_mem [NUM_INSTRUMENTS];
  logic [NUM_INSTRUMENTS-1:0] vld_q;
  logic [MID_W-1:0]           mem_rd_q;
  logic                       vld_rd_q;
  logic                       mem_we;

  // lookup index
  logic [CMP_W-1:0] inst_ext;
  logic [IDX_W-1:0] rd_idx;

  // evaluation
  logic [MID_W-1:0]    mid_sum;
  logic [MID_W-1:0]    mid_w;
  logic [MID_W-1:0]    stored_mid;
  logic [SPREAD_W-1:0] pulled;
  logic [SPREAD_W-1:0] boff, aoff;

  // quote arithmetic
  logic [MID_W-1:0]         mid_q;
  logic [OFFS_W-1:0]        prod_b_q, prod_a_q;
  logic [TICK_W-1:0]        r_q;
  logic signed [WORK_W-1:0] bq_raw, aq_raw, r_ext, t_ext;
  logic signed [WORK_W-1:0] bq_d, aq_d;
  logic signed [WORK_W-1:0] bq_q, aq_q;
  logic signed [NET_W:0]    net_ext, lim_ext;
  logic                     bid_ok, ask_ok;

  // remainder unit
  logic [TICK_W-1:0] rem;
  div_stat_t         div_stat;

  // result held until the output is free
  status_e            res_status_q;
  logic               res_bsend_q, res_bclose_q, res_asend_q, res_aclose_q;
  logic [QUOTE_W-1:0] res_bq_q, res_aq_q;

  // output register
  logic out_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q <= SPREAD_RST;
      maxpos_q <= MAXPOS_RST;
      tick_q   <= TICK_RST;
      minpx_q  <= MINPX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SPREAD_TICKS: spread_q <= cfg_data_i[SPREAD_W-1:0];
        CFG_MAX_NET_POS:  maxpos_q <= cfg_data_i[MAXPOS_W-1:0];
        CFG_TICK_INCR:    tick_q   <= cfg_data_i[TICK_W-1:0];
        CFG_MIN_VALID:    minpx_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // lookup index from the incoming tick
  assign inst_ext = CMP_W'(instrument_i);
  assign rd_idx   = inst_ext[IDX_W-1:0];

  // checks and mid
  always_comb begin
    mid_sum    = MID_W'({1'b0, bid_q} + {1'b0, ask_q} + MID_W'(1));
    mid_w      = {1'b0, mid_sum[MID_W-1:1]};
    stored_mid = vld_rd_q ? mem_rd_q : '0;
    eval_go    = 1'b0;
    if (!ready_q || !inrange_q) begin
      eval_status = ST_NOT_READY;
    end else if ((bid_q <= minpx_q) || (ask_q <= minpx_q)) begin
      eval_status = ST_DIRTY;
    end else if ((last_q >= upper_q) || (last_q <= lower_q)) begin
      eval_status = ST_AT_LIMIT;
    end else if (mid_w == stored_mid) begin
      eval_status = ST_MID_SAME;
    end else begin
      eval_status = ST_REQUOTED;
      eval_go     = 1'b1;
    end
  end

  // inventory skew: the reducing side gets one tick less than the spread, but never under one tick
  always_comb begin
    pulled = (spread_q <= SPREAD_W'(2)) ? SPREAD_W'(1) : spread_q - SPREAD_W'(1);
    boff   = (net_q < 0) ? pulled : spread_q;
    aoff   = (net_q > 0) ? pulled : spread_q;
  end

  // quote alignment from the mid remainder
  always_comb begin
    bq_raw = $signed({2'b00, mid_q}) - $signed({{(WORK_W-OFFS_W){1'b0}}, prod_b_q});
    aq_raw = $signed({2'b00, mid_q}) + $signed({{(WORK_W-OFFS_W){1'b0}}, prod_a_q});
    r_ext  = $signed({{(WORK_W-TICK_W){1'b0}}, r_q});
    t_ext  = $signed({{(WORK_W-TICK_W){1'b0}}, tick_q});
    if ((bq_raw < 0) && (r_q != '0)) begin
      bq_d = bq_raw + t_ext - r_ext;
    end else begin
      bq_d = bq_raw - r_ext;
    end
    aq_d = aq_raw - r_ext;
  end

  // position limits
  always_comb begin
    net_ext = (NET_W+1)'(net_q);
    lim_ext = $signed({2'b00, maxpos_q});
    bid_ok  = (net_ext < lim_ext);
    ask_ok  = (net_ext > -lim_ext);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != S_IDLE);
    accept     = in_valid_i && (state_q == S_IDLE);
    div_start  = 1'b0;
    push       = 1'b0;
    mem_we     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (eval_go) begin
          div_start = 1'b1;
          mem_we    = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_stat.done) state_d = S_QUOTE;
      end
      S_QUOTE: state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // mid memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mid_mem[idx_q] <= mid_w;
    if (accept) begin
      mem_rd_q <= mid_mem[rd_idx];
      vld_rd_q <= vld_q[rd_idx];
    end
  end

  // valid bits for the stored mids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[idx_q] <= 1'b1;
    end
  end

  // tick capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ready_q   <= engine_ready_i;
      inrange_q <= (inst_ext < NUM_C);
      idx_q     <= rd_idx;
      bid_q     <= bid_in_i;
      ask_q     <= ask_in_i;
      last_q    <= last_trade_i;
      upper_q   <= upper_bound_i;
      lower_q   <= lower_bound_i;
      net_q     <= net_position_i;
    end
  end

  // quote datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_EVAL) begin
      res_status_q <= eval_status;
      res_bsend_q  <= 1'b0;
      res_bclose_q <= 1'b0;
      res_bq_q     <= '0;
      res_asend_q  <= 1'b0;
      res_aclose_q <= 1'b0;
      res_aq_q     <= '0;
      mid_q        <= mid_w;
      prod_b_q     <= {{TICK_W{1'b0}}, boff} * {{SPREAD_W{1'b0}}, tick_q};
      prod_a_q     <= {{TICK_W{1'b0}}, aoff} * {{SPREAD_W{1'b0}}, tick_q};
    end
    if ((state_q == S_DIV) && div_stat.done) begin
      r_q <= (tick_q == '0) ? '0 : rem;
    end
    if (state_q == S_QUOTE) begin
      bq_q <= bq_d;
      aq_q <= aq_d;
    end
    if (state_q == S_FIN) begin
      if (bq_q >= aq_q) begin
        res_status_q <= ST_CROSSED;
      end else begin
        res_status_q <= ST_REQUOTED;
        if (bid_ok) begin
          res_bsend_q  <= 1'b1;
          res_bq_q     <= bq_q[QUOTE_W-1:0];
          res_bclose_q <= (net_q < 0);
        end
        if (ask_ok) begin
          res_asend_q  <= 1'b1;
          res_aq_q     <= aq_q[QUOTE_W-1:0];
          res_aclose_q <= (net_q > 0);
        end
      end
    end
  end

  // remainder unit
  isqg_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mid_w),
    .divisor_i  (tick_q),
    .rem_o      (rem),
    .stat_o     (div_stat)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      status_o     <= res_status_q;
      bid_send_o   <= res_bsend_q;
      bid_quote_o  <= $signed(res_bq_q);
      bid_closes_o <= res_bclose_q;
      ask_send_o   <= res_asend_q;
      ask_quote_o  <= res_aq_q;
      ask_closes_o <= res_aclose_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/isqg_assert.sv
`include "inventory_skewed_quote_generator_macros.svh"

module isqg_assert (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [isqg_pkg::STATUS_W-1:0]       status_o,
  input logic                                bid_send_o,
  input logic signed [isqg_pkg::QUOTE_W-1:0] bid_quote_o,
  input logic                                bid_closes_o,
  input logic                                ask_send_o,
  input logic [isqg_pkg::QUOTE_W-1:0]        ask_quote_o,
  input logic                                ask_closes_o
);
  import isqg_pkg::*;

  // a stalled result holds
  `ISQG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(bid_quote_o) && $stable(ask_quote_o), "stalled result changed")

  // an accepted item keeps the block busy
  `ISQG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "block took a second item at once")

  // skipped and crossed ticks carry no quote
  `ISQG_ASSERT_IMPL(a_skip_empty, out_valid_o && (status_o == ST_NOT_READY || status_o == ST_DIRTY || status_o == ST_AT_LIMIT || status_o == ST_MID_SAME || status_o == ST_CROSSED), !bid_send_o && !ask_send_o && !bid_closes_o && !ask_closes_o && (bid_quote_o == '0) && (ask_quote_o == '0), "quote fields set on a skipped tick")

  // a two-sided quote is never crossed
  `ISQG_ASSERT_IMPL(a_not_crossed, out_valid_o && bid_send_o && ask_send_o, $signed(bid_quote_o) < $signed({1'b0, ask_quote_o}), "two-sided quote crossed")

endmodule

bind inventory_skewed_quote_generator isqg_assert u_isqg_assert (.*);
